FILE: rtl/rtc_pkg.sv
// rtc_pkg: shared constants, payload types and fixed-point helpers for the
// ray/triangle closest-hit block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtc_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int INDEX_BITS = 16;
  localparam int INNER_BITS = 56;
  localparam int EPS_BITS   = 16;
  localparam int DIST_BITS  = 31;
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
  localparam int MUL_HALF   = INNER_BITS / 2;
  localparam int RECIP_BITS = 2 * FRAC_BITS + 1;

  localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(7);
  localparam logic [INNER_BITS-1:0] IMAX = {1'b0, {(INNER_BITS-1){1'b1}}};
  localparam logic signed [INNER_BITS+1:0] IMAX_W = {3'b000, {(INNER_BITS-1){1'b1}}};
  localparam logic [INNER_BITS-1:0] ONE = {{(INNER_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  localparam logic [2:0] OUT_HIT      = 3'd0;
  localparam logic [2:0] OUT_PARALLEL = 3'd1;
  localparam logic [2:0] OUT_U_OUT    = 3'd2;
  localparam logic [2:0] OUT_V_OUT    = 3'd3;
  localparam logic [2:0] OUT_DIST     = 3'd4;
  localparam logic [2:0] OUT_LOADED   = 3'd5;

  localparam logic KIND_LOAD = 1'b0;

  typedef logic [2:0][INNER_BITS-1:0] vec_t;
  typedef logic [2:0][COORD_BITS-1:0] cvec_t;

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_BITS-1:0]  a_x;
    logic signed [COORD_BITS-1:0]  a_y;
    logic signed [COORD_BITS-1:0]  a_z;
    logic signed [COORD_BITS-1:0]  b_x;
    logic signed [COORD_BITS-1:0]  b_y;
    logic signed [COORD_BITS-1:0]  b_z;
    logic signed [COORD_BITS-1:0]  c_x;
    logic signed [COORD_BITS-1:0]  c_y;
    logic signed [COORD_BITS-1:0]  c_z;
    logic [INDEX_BITS-1:0]         triangle_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            outcome;
    logic [DIST_BITS-1:0]  distance;
    logic [INDEX_BITS-1:0] tested_index;
    logic [DIST_BITS-1:0]  closest_distance_out;
    logic [INDEX_BITS-1:0] closest_index_out;
    logic                  closest_valid_out;
  } out_item_t;

  // queue entry: for a ray load e1 holds the direction, sign-extended
  typedef struct packed {
    logic                  kind;
    cvec_t                 v0;
    vec_t                  e1;
    vec_t                  e2;
    logic [INDEX_BITS-1:0] idx;
  } entry_t;

  function automatic logic signed [INNER_BITS+1:0] cext_f(input logic [COORD_BITS-1:0] x);
    return {{(INNER_BITS+2-COORD_BITS){x[COORD_BITS-1]}}, x};
  endfunction

  function automatic logic signed [INNER_BITS+1:0] ext_f(input logic [INNER_BITS-1:0] x);
    return {{2{x[INNER_BITS-1]}}, x};
  endfunction

  // symmetric saturation to +-IMAX
  function automatic logic [INNER_BITS-1:0] sat_f(input logic signed [INNER_BITS+1:0] x);
    logic [INNER_BITS-1:0] r;
    if (x > IMAX_W) r = IMAX;
    else if (x < -IMAX_W) r = -IMAX;
    else r = x[INNER_BITS-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rtc_front.sv
// rtc_front: accepts input transactions, forms edge vectors and holds them in
// a short queue for the back end. Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire rtc_pkg::in_item_t in_item,
  output logic                   in_full,
  output logic                   q_valid,
  output rtc_pkg::entry_t        q_entry,
  input  wire logic              q_take
);

  rtc_pkg::entry_t mem_r [rtc_pkg::QDEPTH];
  logic [rtc_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [rtc_pkg::QCNT_BITS-1:0] count_r;
  rtc_pkg::entry_t ent;
  rtc_pkg::cvec_t av, bv, cv;
  logic push_ok, take_ok;

  assign av = {in_item.a_z, in_item.a_y, in_item.a_x};
  assign bv = {in_item.b_z, in_item.b_y, in_item.b_x};
  assign cv = {in_item.c_z, in_item.c_y, in_item.c_x};

  always_comb begin
    ent.kind = in_item.kind;
    ent.v0   = av;
    ent.idx  = in_item.triangle_index;
    for (int i = 0; i < 3; i++) begin
      if (in_item.kind == rtc_pkg::KIND_LOAD) begin
        ent.e1[i] = rtc_pkg::INNER_BITS'(rtc_pkg::cext_f(bv[i]));
        ent.e2[i] = '0;
      end else begin
        ent.e1[i] = rtc_pkg::sat_f(rtc_pkg::cext_f(bv[i]) - rtc_pkg::cext_f(av[i]));
        ent.e2[i] = rtc_pkg::sat_f(rtc_pkg::cext_f(cv[i]) - rtc_pkg::cext_f(av[i]));
      end
    end
  end

  assign in_full = (count_r == rtc_pkg::QCNT_BITS'(rtc_pkg::QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign take_ok = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        mem_r[wr_ptr_r] <= ent;
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (take_ok) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_ok && !take_ok) count_r <= count_r + 1'b1;
      else if (!push_ok && take_ok) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rtc_mulq.sv
// rtc_mulq: fixed-point product (a*b)>>FRAC_BITS, truncated toward zero and
// saturated, from four half-width partial products. Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtc_mulq (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [rtc_pkg::INNER_BITS-1:0]  a,
  input  wire logic [rtc_pkg::INNER_BITS-1:0]  b,
  output logic                                 done,
  output logic [rtc_pkg::INNER_BITS-1:0]       res
);

  localparam int H   = rtc_pkg::MUL_HALF;
  localparam int ACC = 4 * H;
  localparam int SHW = $clog2(2 * H + 1);

  logic busy_r, done_r, neg_r;
  logic [2:0] step_r;
  logic [2*H-1:0] ma_r, mb_r, pp_r;
  logic [SHW-1:0] sh_r;
  logic [ACC-1:0] acc_r, shifted;
  logic [rtc_pkg::INNER_BITS-1:0] res_r, mag;
  logic [H-1:0] x, y;
  logic [SHW-1:0] sh;

  always_comb begin
    case (step_r[1:0])
      2'd0: begin x = ma_r[H-1:0];   y = mb_r[H-1:0];   sh = '0; end
      2'd1: begin x = ma_r[H-1:0];   y = mb_r[2*H-1:H]; sh = SHW'(H); end
      2'd2: begin x = ma_r[2*H-1:H]; y = mb_r[H-1:0];   sh = SHW'(H); end
      default: begin x = ma_r[2*H-1:H]; y = mb_r[2*H-1:H]; sh = SHW'(2 * H); end
    endcase
    shifted = acc_r >> rtc_pkg::FRAC_BITS;
    if (|shifted[ACC-1:rtc_pkg::INNER_BITS-1]) mag = rtc_pkg::IMAX;
    else mag = {1'b0, shifted[rtc_pkg::INNER_BITS-2:0]};
  end

  assign done = done_r;
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          step_r <= '0;
          acc_r  <= '0;
          neg_r  <= a[rtc_pkg::INNER_BITS-1] ^ b[rtc_pkg::INNER_BITS-1];
          ma_r   <= a[rtc_pkg::INNER_BITS-1] ? -a : a;
          mb_r   <= b[rtc_pkg::INNER_BITS-1] ? -b : b;
        end
      end else if (step_r == 3'd5) begin
        res_r  <= neg_r ? -mag : mag;
        done_r <= 1'b1;
        busy_r <= 1'b0;
      end else begin
        if (step_r < 3'd4) begin
          pp_r <= x * y;
          sh_r <= sh;
        end
        if (step_r != 3'd0) acc_r <= acc_r + ({{(ACC-2*H){1'b0}}, pp_r} << sh_r);
        step_r <= step_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rtc_recip.sv
// rtc_recip: restoring divider for 2^(2*FRAC_BITS) / mag, one quotient bit
// per cycle. Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtc_recip (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [rtc_pkg::INNER_BITS-2:0]   mag,
  output logic                                  done,
  output logic [rtc_pkg::RECIP_BITS-1:0]        quo
);

  localparam int CW = $clog2(rtc_pkg::RECIP_BITS);

  logic busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [rtc_pkg::INNER_BITS-2:0] div_r;
  logic [rtc_pkg::INNER_BITS-1:0] rem_r;
  logic [rtc_pkg::RECIP_BITS-1:0] quo_r;
  logic [rtc_pkg::INNER_BITS:0] trial, diff;
  logic fits;

  // dividend is a single one at its top bit
  assign trial = {rem_r, (cnt_r == CW'(rtc_pkg::RECIP_BITS - 1))};
  assign diff  = trial - {2'b00, div_r};
  assign fits  = trial >= {2'b00, div_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(rtc_pkg::RECIP_BITS - 1);
          rem_r  <= '0;
          div_r  <= mag;
        end
      end else begin
        rem_r <= fits ? diff[rtc_pkg::INNER_BITS-1:0] : trial[rtc_pkg::INNER_BITS-1:0];
        quo_r <= {quo_r[rtc_pkg::RECIP_BITS-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rtc_back.sv
// rtc_back: sequencer that runs the intersection test on the shared product
// unit and divider, holds the ray and closest record, and the result register.
// Depends on rtc_pkg, rtc_mulq, rtc_recip.
`timescale 1ns / 1ps
`default_nettype none
module rtc_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [rtc_pkg::EPS_BITS-1:0]    eps,
  input  wire logic                            q_valid,
  input  wire rtc_pkg::entry_t                 q_entry,
  output logic                                 q_take,
  input  wire logic                            out_pop,
  output logic                                 out_empty,
  output rtc_pkg::out_item_t                   out_item
);

  localparam int IB = rtc_pkg::INNER_BITS;

  typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_COMB, ST_RECIP} state_t;
  typedef enum logic [3:0] {
    OP_P, OP_DET, OP_U1, OP_U2, OP_Q, OP_V1, OP_V2, OP_D1, OP_D2
  } op_t;

  state_t state_r;
  op_t    op_r;
  logic [2:0] k_r, k_last;
  rtc_pkg::cvec_t org_r, dir_r;
  rtc_pkg::vec_t  e1_r, e2_r, t_r, p_r, q_r, dirv, va, vb, cross_w;
  logic [5:0][IB-1:0] prod_r;
  logic [IB-1:0] s_r, inv_r, u_r, sum_s, det_abs, epsw, invv, mul_a, mul_b, mul_res;
  logic [IB-1:0] closew;
  logic det_neg_r, scalar, det_par, u_bad, v_bad, d_bad;
  logic [1:0] ia, ib;
  logic [rtc_pkg::INDEX_BITS-1:0] idx_r, close_idx_r;
  logic [rtc_pkg::DIST_BITS-1:0] close_dist_r;
  logic close_valid_r, out_valid_r, mul_start, mul_done, recip_start, recip_done;
  logic [rtc_pkg::RECIP_BITS-1:0] recip_q;
  rtc_pkg::out_item_t out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) dirv[i] = IB'(rtc_pkg::cext_f(dir_r[i]));
    scalar = 1'b0;
    case (op_r)
      OP_P:    begin va = dirv; vb = e2_r; end
      OP_DET:  begin va = e1_r; vb = p_r;  end
      OP_U1:   begin va = t_r;  vb = p_r;  end
      OP_Q:    begin va = t_r;  vb = e1_r; end
      OP_V1:   begin va = dirv; vb = q_r;  end
      OP_D1:   begin va = e2_r; vb = q_r;  end
      default: begin va = dirv; vb = q_r; scalar = 1'b1; end
    endcase
    // cross products take six terms, dot products three, scalar products one
    if (op_r == OP_P || op_r == OP_Q) begin
      k_last = 3'd5;
      case (k_r)
        3'd0: begin ia = 2'd1; ib = 2'd2; end
        3'd1: begin ia = 2'd2; ib = 2'd1; end
        3'd2: begin ia = 2'd2; ib = 2'd0; end
        3'd3: begin ia = 2'd0; ib = 2'd2; end
        3'd4: begin ia = 2'd0; ib = 2'd1; end
        default: begin ia = 2'd1; ib = 2'd0; end
      endcase
    end else begin
      k_last = scalar ? 3'd0 : 3'd2;
      ia = k_r[1:0];
      ib = k_r[1:0];
    end
    mul_a = scalar ? s_r : va[ia];
    mul_b = scalar ? inv_r : vb[ib];

    for (int i = 0; i < 3; i++)
      cross_w[i] = rtc_pkg::sat_f(rtc_pkg::ext_f(prod_r[2*i]) - rtc_pkg::ext_f(prod_r[2*i+1]));
    sum_s = rtc_pkg::sat_f(rtc_pkg::ext_f(prod_r[0]) + rtc_pkg::ext_f(prod_r[1])
                           + rtc_pkg::ext_f(prod_r[2]));
    epsw    = {{(IB-rtc_pkg::EPS_BITS){1'b0}}, eps};
    closew  = {{(IB-rtc_pkg::DIST_BITS){1'b0}}, close_dist_r};
    det_par = (sum_s == '0) || ($signed(sum_s) > -$signed(epsw) && $signed(sum_s) < $signed(epsw));
    det_abs = sum_s[IB-1] ? -sum_s : sum_s;
    invv    = {{(IB-rtc_pkg::RECIP_BITS){1'b0}}, recip_q};
    u_bad   = prod_r[0][IB-1] || ($signed(prod_r[0]) > $signed(rtc_pkg::ONE));
    v_bad   = prod_r[0][IB-1] || ((rtc_pkg::ext_f(u_r) + rtc_pkg::ext_f(prod_r[0]))
                                  > rtc_pkg::ext_f(rtc_pkg::ONE));
    d_bad   = ($signed(prod_r[0]) < $signed(epsw)) || ($signed(prod_r[0]) > $signed(closew));
  end

  assign q_take      = (state_r == ST_IDLE) && q_valid && !out_valid_r;
  assign mul_start   = (state_r == ST_ISSUE);
  assign recip_start = (state_r == ST_COMB) && (op_r == OP_DET) && !det_par;
  assign out_empty   = !out_valid_r;
  assign out_item    = out_r;

  rtc_mulq u_mulq (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  rtc_recip u_recip (
    .clk(clk), .rst_n(rst_n), .start(recip_start), .mag(det_abs[IB-2:0]),
    .done(recip_done), .quo(recip_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      op_r          <= OP_P;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
      org_r         <= '0;
      dir_r         <= '0;
      close_dist_r  <= rtc_pkg::DIST_MAX;
      close_idx_r   <= '0;
      close_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_take) begin
            idx_r <= q_entry.idx;
            if (q_entry.kind == rtc_pkg::KIND_LOAD) begin
              org_r <= q_entry.v0;
              for (int i = 0; i < 3; i++) dir_r[i] <= q_entry.e1[i][rtc_pkg::COORD_BITS-1:0];
              close_dist_r  <= rtc_pkg::DIST_MAX;
              close_idx_r   <= '0;
              close_valid_r <= 1'b0;
              out_r <= '{rtc_pkg::OUT_LOADED, '0, q_entry.idx, rtc_pkg::DIST_MAX, '0, 1'b0};
              out_valid_r <= 1'b1;
            end else begin
              for (int i = 0; i < 3; i++)
                t_r[i] <= rtc_pkg::sat_f(rtc_pkg::cext_f(org_r[i])
                                         - rtc_pkg::cext_f(q_entry.v0[i]));
              e1_r    <= q_entry.e1;
              e2_r    <= q_entry.e2;
              op_r    <= OP_P;
              k_r     <= '0;
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            prod_r[k_r] <= mul_res;
            if (k_r == k_last) begin
              state_r <= ST_COMB;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_RECIP: begin
          if (recip_done) begin
            inv_r   <= det_neg_r ? -invv : invv;
            op_r    <= OP_U1;
            k_r     <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_COMB: begin
          k_r     <= '0;
          state_r <= ST_ISSUE;
          case (op_r)
            OP_P: begin
              p_r  <= cross_w;
              op_r <= OP_DET;
            end
            OP_DET: begin
              det_neg_r <= sum_s[IB-1];
              if (det_par) begin
                out_r <= '{rtc_pkg::OUT_PARALLEL, '0, idx_r, close_dist_r, close_idx_r,
                           close_valid_r};
                out_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else begin
                state_r <= ST_RECIP;
              end
            end
            OP_U1: begin
              s_r  <= sum_s;
              op_r <= OP_U2;
            end
            OP_U2: begin
              u_r <= prod_r[0];
              if (u_bad) begin
                out_r <= '{rtc_pkg::OUT_U_OUT, '0, idx_r, close_dist_r, close_idx_r,
                           close_valid_r};
                out_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else begin
                op_r <= OP_Q;
              end
            end
            OP_Q: begin
              q_r  <= cross_w;
              op_r <= OP_V1;
            end
            OP_V1: begin
              s_r  <= sum_s;
              op_r <= OP_V2;
            end
            OP_V2: begin
              if (v_bad) begin
                out_r <= '{rtc_pkg::OUT_V_OUT, '0, idx_r, close_dist_r, close_idx_r,
                           close_valid_r};
                out_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else begin
                op_r <= OP_D1;
              end
            end
            OP_D1: begin
              s_r  <= sum_s;
              op_r <= OP_D2;
            end
            default: begin
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
              if (d_bad) begin
                out_r <= '{rtc_pkg::OUT_DIST, '0, idx_r, close_dist_r, close_idx_r,
                           close_valid_r};
              end else begin
                close_dist_r  <= prod_r[0][rtc_pkg::DIST_BITS-1:0];
                close_idx_r   <= idx_r;
                close_valid_r <= 1'b1;
                out_r <= '{rtc_pkg::OUT_HIT, prod_r[0][rtc_pkg::DIST_BITS-1:0], idx_r,
                           prod_r[0][rtc_pkg::DIST_BITS-1:0], idx_r, 1'b1};
              end
            end
          endcase
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> !out_valid_r) else $error("queue taken while result pending");
  a_rose_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> state_r == ST_IDLE) else $error("result posted mid-test");
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.outcome != rtc_pkg::OUT_HIT) |-> out_r.distance == '0)
    else $error("distance on a miss");
  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_WAIT) else $error("product arrived unexpectedly");
`endif

endmodule
`default_nettype wire

FILE: rtl/ray_triangle_closest_hit.sv
// ray_triangle_closest_hit: top level; epsilon register, front queue and
// back-end sequencer. Depends on rtc_pkg, rtc_front, rtc_back.
//
// Usage:
//  - Input queue: drive in_item and raise in_push; a transaction is taken on
//    a clock edge with in_push high and in_full low. kind 0 loads a ray
//    (a = origin, b = direction) and clears the closest record; kind 1 tests
//    the triangle a, b, c against the held ray.
//  - Result register: while out_empty is low, out_item holds the pending result;
//    it is taken on an edge with out_pop high. Every input gives one result.
//  - cfg_we/cfg_wdata write epsilon (reset 7); write only while idle.
//  - The front forms edge vectors and buffers two transactions, so input is
//    taken while a result waits or the back end is busy.
//  - A ray load is answered without the product unit or the divider. A
//    triangle runs on one shared product unit (built from 4 28x28 partial
//    products) and a bit-serial divider: a parallel rejection stops before
//    the divider, a full test uses 27 products plus the divider. Items are
//    processed one at a time.
//  - When the receiver stalls the result register holds, the back end stops
//    at its next item, and in_full rises once the queue fills.
//  - Reset (synchronous, rst_n low) empties the input queue and the result
//    register, zeroes the ray and sets closest distance to maximum with no hit.
`timescale 1ns / 1ps
`default_nettype none
module ray_triangle_closest_hit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  input  wire rtc_pkg::in_item_t               in_item,
  output logic                                 in_full,
  input  wire logic                            out_pop,
  output rtc_pkg::out_item_t                   out_item,
  output logic                                 out_empty,
  input  wire logic                            cfg_we,
  input  wire logic [rtc_pkg::EPS_BITS-1:0]    cfg_wdata
);

  logic [rtc_pkg::EPS_BITS-1:0] eps_r;
  logic q_valid, q_take;
  rtc_pkg::entry_t q_entry;

  // epsilon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= rtc_pkg::EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  rtc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_item(in_item),
    .in_full(in_full), .q_valid(q_valid), .q_entry(q_entry), .q_take(q_take)
  );

  rtc_back u_back (
    .clk(clk), .rst_n(rst_n), .eps(eps_r), .q_valid(q_valid), .q_entry(q_entry),
    .q_take(q_take), .out_pop(out_pop), .out_empty(out_empty), .out_item(out_item)
  );

endmodule
`default_nettype wire
